@@ rtl/mta_pkg.sv @@
// mta_pkg: shared types and constants for the mesh tangent accumulator
// holds the vertex record layout, command codes and sequencer states
// no dependencies
package mta_pkg;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_TRI  = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   // cross product phase that forms the uv determinant
   localparam logic [1:0] PHASE_DET = 2'd3;
   localparam logic [1:0] LAST_AXIS = 2'd2;

   localparam int DIV_W    = 64;
   localparam int MEAN_LEN = 41;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [1:0][31:0] tex;
      logic [2:0][31:0] tan;
      logic [7:0]       count;
      logic             mark;
   } vtx_rec_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_TRI_RB,
      ST_TRI_RC,
      ST_DELTA,
      ST_MUL1,
      ST_MUL2,
      ST_CROSS,
      ST_RECIP,
      ST_RECIP_WAIT,
      ST_TMUL,
      ST_TSCALE,
      ST_FOLD_RD,
      ST_FOLD_CAP,
      ST_FOLD_MUL,
      ST_FOLD_DIV,
      ST_FOLD_WAIT,
      ST_FOLD_WR
   } state_type;

   function automatic logic [31:0] sat32(input logic signed [64:0] v);
      logic [31:0] r;
      if (v > 65'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -65'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // b - a, exact, then saturated
   function automatic logic [31:0] delta32(input logic [31:0] a, input logic [31:0] b);
      logic signed [64:0] d;
      d = $signed({{33{b[31]}}, b}) - $signed({{33{a[31]}}, a});
      return sat32(d);
   endfunction

endpackage

@@ rtl/mesh_tangent_accumulator.sv @@
// mesh_tangent_accumulator: per-vertex tangent accumulation over a vertex store
// uses mta_pkg; one shared 32x32 multiplier and one bit-serial divider under a sequencer
// Load is written at its transfer edge and busy stays low; a read holds busy in ST_READ
//   and strobes rsp_valid in the cycle after.
// Triangle: busy for setup, reciprocal and tangent (only setup on a zero determinant),
//   then per corner a read, a mean divide per axis when its count is nonzero, and a write.
// One item at a time, results cannot be stalled; reset clears sequencer, strobe and divider count only.
module mesh_tangent_accumulator
   import mta_pkg::*;
#(
   parameter int VERTEX_DEPTH  = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_vertex_index,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_tex_u,
   input  logic [31:0] req_tex_v,
   input  logic [9:0]  req_corner_b,
   input  logic [9:0]  req_corner_c,
   output logic        rsp_valid,
   output logic [31:0] rsp_tangent_x,
   output logic [31:0] rsp_tangent_y,
   output logic [31:0] rsp_tangent_z,
   output logic [7:0]  rsp_contributions,
   output logic        rsp_degenerate_seen
);

   localparam int IDX_W     = $clog2(VERTEX_DEPTH);
   localparam int RECIP_LEN = 2 * FRACTION_BITS + 1;
   localparam logic [63:0] RECIP_NUM  = 64'd1 << (2 * FRACTION_BITS);
   localparam logic [63:0] RECIP_LOAD = RECIP_NUM << (DIV_W - RECIP_LEN);
   localparam logic [64:0] FRAC_MASK  = (65'd1 << FRACTION_BITS) - 65'd1;

   vtx_rec_type vertex_mem [VERTEX_DEPTH];

   state_type state_ff, state_in;

   vtx_rec_type rd_data_ff, rec_a_ff, rec_b_ff, cur_ff;
   logic [2:0][IDX_W-1:0] corner_ff;
   logic        oor_ff;
   logic [2:0][31:0] e1_ff, e2_ff, t_ff, newt_ff;
   logic [31:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic [31:0] recip_ff, num_ff;
   logic        degen_ff;
   logic [1:0]  k_ff, j_ff, m_ff;
   logic signed [63:0] prod1_ff, prod2_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [7:0]  rsp_cnt_ff;
   logic        rsp_mark_ff;

   // divider
   logic [31:0]      div_rem_ff, div_den_ff;
   logic [DIV_W-1:0] div_quo_ff;
   logic [6:0]       div_cnt_ff;
   logic             div_neg_ff;
   logic [32:0]      div_shift, div_diff;
   logic             div_ge;

   logic             accept;
   logic [IDX_W-1:0] req_idx, req_b_idx, req_c_idx;
   logic             in_a, in_b, in_c;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   vtx_rec_type      wr_data;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic [31:0]      cross_sat;
   logic signed [63:0] mean_num;
   logic [63:0]      mean_mag;
   logic [63:0]      quo_signed;
   logic [7:0]       cnt_next;

   function automatic logic signed [64:0] shr_trunc(input logic signed [64:0] x);
      logic signed [64:0] bias;
      bias = x[64] ? $signed(FRAC_MASK) : 65'sd0;
      return (x + bias) >>> FRACTION_BITS;
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(input logic [9:0] v);
      logic [16:0] ext;
      ext = {7'd0, v};
      return ext[IDX_W-1:0];
   endfunction

   function automatic logic in_range(input logic [9:0] v);
      return {7'd0, v} < 17'(VERTEX_DEPTH);
   endfunction

   assign accept    = start && !busy;
   assign req_idx   = to_idx(req_vertex_index);
   assign req_b_idx = to_idx(req_corner_b);
   assign req_c_idx = to_idx(req_corner_c);
   assign in_a      = in_range(req_vertex_index);
   assign in_b      = in_range(req_corner_b);
   assign in_c      = in_range(req_corner_c);

   assign mul_p     = mul_a * mul_b;
   assign cross_sat = sat32(shr_trunc($signed({prod1_ff[63], prod1_ff})
                                      - $signed({prod2_ff[63], prod2_ff})));
   assign mean_num  = prod1_ff + $signed({{32{t_ff[m_ff][31]}}, t_ff[m_ff]});
   assign mean_mag  = mean_num[63] ? 64'(-mean_num) : 64'(mean_num);
   assign quo_signed = div_neg_ff ? -div_quo_ff : div_quo_ff;
   assign cnt_next  = (cur_ff.count == COUNT_MAX) ? COUNT_MAX : cur_ff.count + 8'd1;

   assign div_shift = {div_rem_ff, div_quo_ff[DIV_W-1]};
   assign div_diff  = div_shift - {1'b0, div_den_ff};
   assign div_ge    = div_shift >= {1'b0, div_den_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_READ) begin
                  state_in = ST_READ;
               end else if (req_func == FUNC_TRI && in_a && in_b && in_c) begin
                  state_in = ST_TRI_RB;
               end
            end
         end
         ST_READ:       state_in = ST_IDLE;
         ST_TRI_RB:     state_in = ST_TRI_RC;
         ST_TRI_RC:     state_in = ST_DELTA;
         ST_DELTA:      state_in = ST_MUL1;
         ST_MUL1:       state_in = ST_MUL2;
         ST_MUL2:       state_in = ST_CROSS;
         ST_CROSS: begin
            if (k_ff != PHASE_DET) begin
               state_in = ST_TMUL;
            end else if (cross_sat == 32'd0) begin
               state_in = ST_FOLD_RD;
            end else begin
               state_in = ST_RECIP;
            end
         end
         ST_RECIP:      state_in = ST_RECIP_WAIT;
         ST_RECIP_WAIT: if (div_cnt_ff == 7'd0) state_in = ST_MUL1;
         ST_TMUL:       state_in = ST_TSCALE;
         ST_TSCALE:     state_in = (k_ff == LAST_AXIS) ? ST_FOLD_RD : ST_MUL1;
         ST_FOLD_RD:    state_in = ST_FOLD_CAP;
         ST_FOLD_CAP:   state_in = (rd_data_ff.count == 8'd0) ? ST_FOLD_WR : ST_FOLD_MUL;
         ST_FOLD_MUL:   state_in = ST_FOLD_DIV;
         ST_FOLD_DIV:   state_in = ST_FOLD_WAIT;
         ST_FOLD_WAIT: begin
            if (div_cnt_ff == 7'd0) begin
               state_in = (m_ff == LAST_AXIS) ? ST_FOLD_WR : ST_FOLD_MUL;
            end
         end
         ST_FOLD_WR:    state_in = (j_ff == LAST_AXIS) ? ST_IDLE : ST_FOLD_RD;
         default:       state_in = ST_IDLE;
      endcase
   end

   // outputs, memory control and multiplier operands
   always_comb begin
      busy    = state_ff != ST_IDLE;
      rd_addr = req_idx;
      wr_en   = 1'b0;
      wr_addr = req_idx;
      wr_data = '0;
      mul_a   = '0;
      mul_b   = '0;
      wr_data.pos[0] = req_pos_x;
      wr_data.pos[1] = req_pos_y;
      wr_data.pos[2] = req_pos_z;
      wr_data.tex[0] = req_tex_u;
      wr_data.tex[1] = req_tex_v;
      case (state_ff)
         ST_IDLE: begin
            wr_en = accept && req_func == FUNC_LOAD && in_a;
         end
         ST_TRI_RB: rd_addr = corner_ff[1];
         ST_TRI_RC: rd_addr = corner_ff[2];
         ST_MUL1: begin
            mul_a = (k_ff == PHASE_DET) ? du1_ff : dv2_ff;
            mul_b = (k_ff == PHASE_DET) ? dv2_ff : e1_ff[k_ff];
         end
         ST_MUL2: begin
            mul_a = dv1_ff;
            mul_b = (k_ff == PHASE_DET) ? du2_ff : e2_ff[k_ff];
         end
         ST_TMUL: begin
            mul_a = recip_ff;
            mul_b = num_ff;
         end
         ST_FOLD_RD: rd_addr = corner_ff[j_ff];
         ST_FOLD_MUL: begin
            mul_a = cur_ff.tan[m_ff];
            mul_b = {24'd0, cur_ff.count};
         end
         ST_FOLD_WR: begin
            wr_en   = 1'b1;
            wr_addr = corner_ff[j_ff];
            wr_data = cur_ff;
            wr_data.tan   = newt_ff;
            wr_data.count = cnt_next;
            wr_data.mark  = cur_ff.mark | degen_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         vertex_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= vertex_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= state_ff == ST_READ;
         if (div_cnt_ff != 7'd0) begin
            div_cnt_ff <= div_cnt_ff - 7'd1;
         end
         if (state_ff == ST_RECIP) begin
            div_cnt_ff <= 7'(RECIP_LEN);
         end else if (state_ff == ST_FOLD_DIV) begin
            div_cnt_ff <= 7'(MEAN_LEN);
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (div_cnt_ff != 7'd0) begin
         div_rem_ff <= div_ge ? div_diff[31:0] : div_shift[31:0];
         div_quo_ff <= {div_quo_ff[DIV_W-2:0], div_ge};
      end
      case (state_ff)
         ST_IDLE: begin
            oor_ff       <= !in_a;
            corner_ff[0] <= req_idx;
            corner_ff[1] <= req_b_idx;
            corner_ff[2] <= req_c_idx;
         end
         ST_READ: begin
            rsp_x_ff    <= oor_ff ? 32'd0 : rd_data_ff.tan[0];
            rsp_y_ff    <= oor_ff ? 32'd0 : rd_data_ff.tan[1];
            rsp_z_ff    <= oor_ff ? 32'd0 : rd_data_ff.tan[2];
            rsp_cnt_ff  <= oor_ff ? 8'd0 : rd_data_ff.count;
            rsp_mark_ff <= oor_ff ? 1'b0 : rd_data_ff.mark;
         end
         ST_TRI_RB: rec_a_ff <= rd_data_ff;
         ST_TRI_RC: rec_b_ff <= rd_data_ff;
         ST_DELTA: begin
            for (int i = 0; i < 3; i++) begin
               e1_ff[i] <= delta32(rec_a_ff.pos[i], rec_b_ff.pos[i]);
               e2_ff[i] <= delta32(rec_a_ff.pos[i], rd_data_ff.pos[i]);
            end
            du1_ff <= delta32(rec_a_ff.tex[0], rec_b_ff.tex[0]);
            dv1_ff <= delta32(rec_a_ff.tex[1], rec_b_ff.tex[1]);
            du2_ff <= delta32(rec_a_ff.tex[0], rd_data_ff.tex[0]);
            dv2_ff <= delta32(rec_a_ff.tex[1], rd_data_ff.tex[1]);
            k_ff   <= PHASE_DET;
            j_ff   <= '0;
         end
         ST_MUL1: prod1_ff <= mul_p;
         ST_MUL2: prod2_ff <= mul_p;
         ST_CROSS: begin
            if (k_ff == PHASE_DET) begin
               degen_ff <= cross_sat == 32'd0;
               t_ff     <= '0;
               // divisor is the determinant magnitude, sign applied afterwards
               div_den_ff <= cross_sat[31] ? -cross_sat : cross_sat;
               div_neg_ff <= cross_sat[31];
            end else begin
               num_ff <= cross_sat;
            end
         end
         ST_RECIP: begin
            div_rem_ff <= '0;
            div_quo_ff <= RECIP_LOAD;
         end
         ST_RECIP_WAIT: begin
            if (div_cnt_ff == 7'd0) begin
               recip_ff <= sat32(div_neg_ff ? -$signed({1'b0, div_quo_ff})
                                            : $signed({1'b0, div_quo_ff}));
               k_ff     <= '0;
            end
         end
         ST_TMUL: prod1_ff <= mul_p;
         ST_TSCALE: begin
            t_ff[k_ff] <= sat32(shr_trunc($signed({prod1_ff[63], prod1_ff})));
            k_ff       <= k_ff + 2'd1;
         end
         ST_FOLD_CAP: begin
            cur_ff  <= rd_data_ff;
            newt_ff <= t_ff;
            m_ff    <= '0;
         end
         ST_FOLD_MUL: prod1_ff <= mul_p;
         ST_FOLD_DIV: begin
            div_rem_ff <= '0;
            div_quo_ff <= mean_mag << (DIV_W - MEAN_LEN);
            div_den_ff <= {24'd0, cur_ff.count} + 32'd1;
            div_neg_ff <= mean_num[63];
         end
         ST_FOLD_WAIT: begin
            if (div_cnt_ff == 7'd0) begin
               newt_ff[m_ff] <= quo_signed[31:0];
               m_ff          <= m_ff + 2'd1;
            end
         end
         ST_FOLD_WR: j_ff <= j_ff + 2'd1;
         default: ;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_tangent_x       = rsp_x_ff;
   assign rsp_tangent_y       = rsp_y_ff;
   assign rsp_tangent_z       = rsp_z_ff;
   assign rsp_contributions   = rsp_cnt_ff;
   assign rsp_degenerate_seen = rsp_mark_ff;

   // a read transfer gives its result through ST_READ and then the registered strobe
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_READ) |-> ##2 rsp_valid)
      else $error("read result missing");

   // a result only shows while the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // the divider never runs with a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (div_cnt_ff != 7'd0) |-> (div_den_ff != 32'd0))
      else $error("divide by zero");

endmodule
